[rtl/core/smss_pkg.sv]
// ============================================================================
// smss_pkg: shared types and constants for the sorted-matrix search unit
// Item layouts, configuration register indexes and the walk controller
// state encoding.
// ============================================================================
package smss_pkg;

    // Default sizes for the top level parameters
    localparam int MAX_ROWS_DEF    = 16;
    localparam int MAX_COLS_DEF    = 16;
    localparam int VALUE_WIDTH_DEF = 32;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    localparam logic [CFG_IDX_W-1:0]  CFG_ROWS_IDX = 2'd0;
    localparam logic [CFG_IDX_W-1:0]  CFG_COLS_IDX = 2'd1;
    localparam logic [CFG_DATA_W-1:0] DIM_RESET    = 5'd16;

    // Opcodes
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    // Request item
    typedef struct packed {
        logic               opcode;
        logic [3:0]         entry_row;
        logic [3:0]         entry_col;
        logic signed [31:0] entry_value;
        logic signed [31:0] search_key;
    } smss_in_t;

    // Response item
    typedef struct packed {
        logic       found;
        logic [3:0] found_row;
        logic [3:0] found_col;
    } smss_out_t;

    // Top level to engine
    typedef struct packed {
        logic start;     // request item accepted this cycle
        logic res_take;  // result moves into the output register
    } smss_ctrl_t;

    // Engine to top level
    typedef struct packed {
        logic idle;
        logic res_valid;
    } smss_stat_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DONE
    } smss_state_t;

endpackage

[rtl/core/smss_engine.sv]
// ============================================================================
// smss_engine: matrix store and staircase walker
// Holds the matrix in a synchronous RAM and walks it one cell per cycle,
// starting at the top-right corner of the active region.
// ============================================================================
module smss_engine
    import smss_pkg::*;
#(
    parameter int MAX_ROWS    = MAX_ROWS_DEF,
    parameter int MAX_COLS    = MAX_COLS_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  smss_ctrl_t            ctrl,
    input  smss_in_t              item,
    input  logic [CFG_DATA_W-1:0] rows_cfg,
    input  logic [CFG_DATA_W-1:0] cols_cfg,
    output smss_stat_t            stat,
    output smss_out_t             result
);

    localparam int DEPTH  = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int RIW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CIW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int RCW    = $clog2(MAX_ROWS + 1);
    localparam int CCW    = $clog2(MAX_COLS + 1);
    localparam logic [ADDR_W-1:0] COL_STEP = ADDR_W'(MAX_COLS);

    logic signed [VALUE_WIDTH-1:0] store_mem [DEPTH];
    logic signed [VALUE_WIDTH-1:0] rd_data_reg;

    smss_state_t                   state_reg, state_next;
    logic [RIW-1:0]                x_reg, x_next;
    logic [CIW-1:0]                col_reg, col_next;
    logic [ADDR_W-1:0]             base_reg, base_next;
    logic [RCW-1:0]                rows_reg, rows_next;
    logic signed [VALUE_WIDTH-1:0] key_reg, key_next;
    smss_out_t                     result_reg, result_next;

    logic [RCW-1:0]                rows_eff;
    logic [CCW-1:0]                cols_eff;
    logic                          wr_en;
    logic [ADDR_W-1:0]             wr_addr;
    logic signed [VALUE_WIDTH-1:0] wr_value;
    logic [ADDR_W-1:0]             rd_base;
    logic [CIW-1:0]                rd_col;
    logic [ADDR_W-1:0]             rd_addr;

    // Region clipped to the store size
    assign rows_eff = (32'(rows_cfg) > MAX_ROWS) ? RCW'(MAX_ROWS) : RCW'(rows_cfg);
    assign cols_eff = (32'(cols_cfg) > MAX_COLS) ? CCW'(MAX_COLS) : CCW'(cols_cfg);

    // Writes outside the store are dropped
    assign wr_en = ctrl.start && (item.opcode == OP_WRITE)
                   && (32'(item.entry_row) < MAX_ROWS)
                   && (32'(item.entry_col) < MAX_COLS);
    assign wr_addr  = ADDR_W'(32'(item.entry_row) * MAX_COLS + 32'(item.entry_col));
    assign wr_value = VALUE_WIDTH'(item.entry_value);

    assign rd_addr = rd_base + ADDR_W'(rd_col);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[wr_addr] <= wr_value;
        end
        rd_data_reg <= store_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg      <= x_next;
        col_reg    <= col_next;
        base_reg   <= base_next;
        rows_reg   <= rows_next;
        key_reg    <= key_next;
        result_reg <= result_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        x_next      = x_reg;
        col_next    = col_reg;
        base_next   = base_reg;
        rows_next   = rows_reg;
        key_next    = key_reg;
        result_next = result_reg;
        rd_base     = base_reg;
        rd_col      = col_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (ctrl.start && (item.opcode == OP_SEARCH))
                begin
                    key_next    = VALUE_WIDTH'(item.search_key);
                    rows_next   = rows_eff;
                    x_next      = '0;
                    base_next   = '0;
                    col_next    = CIW'(cols_eff - CCW'(1));
                    result_next = '0;
                    rd_base     = '0;
                    rd_col      = col_next;
                    if ((rows_eff == '0) || (cols_eff == '0))
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_WALK;
                    end
                end
            end

            ST_WALK:
            begin
                if (rd_data_reg == key_reg)
                begin
                    result_next.found     = 1'b1;
                    result_next.found_row = 4'(x_reg);
                    result_next.found_col = 4'(col_reg);
                    state_next            = ST_DONE;
                end
                else if (rd_data_reg > key_reg)
                begin
                    // step left
                    if (col_reg == '0)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        col_next = col_reg - CIW'(1);
                        rd_col   = col_next;
                    end
                end
                else
                begin
                    // step down
                    if (RCW'(x_reg) + RCW'(1) == rows_reg)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        x_next    = x_reg + RIW'(1);
                        base_next = base_reg + COL_STEP;
                        rd_base   = base_next;
                    end
                end
            end

            ST_DONE:
            begin
                if (ctrl.res_take)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign stat.idle      = (state_reg == ST_IDLE);
    assign stat.res_valid = (state_reg == ST_DONE);
    assign result         = result_reg;

endmodule

[rtl/core/sorted_matrix_staircase_search_unit.sv]
// ============================================================================
// sorted_matrix_staircase_search_unit: saddleback search over a sorted matrix
// Stores a matrix with ascending rows and columns and searches it for keys.
// ============================================================================
//
// Usage:
//  - Request channel (req_valid / req_stall / req_item): a write item stores
//    entry_value at (entry_row, entry_col) and returns nothing; a search item
//    returns one response item (found, found_row, found_col).
//  - Response channel (rsp_valid / rsp_stall / rsp_item): one output register.
//  - Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data): sets the
//    active region rows_in_use x cols_in_use; always ready. Write only while
//    the block is idle.
//  - A write item is stored without the engine leaving idle. A search walks
//    the active region from its top-right corner and visits at most
//    rows + cols - 1 cells (one RAM read and compare per cell). The engine
//    returns to idle as the response register is loaded, and only then takes the next item.
//    One item is in work at a time; req_stall is high while a search walks
//    or its result is waiting for the output register.
//  - Reset: region back to 16x16, no response pending. Matrix contents are
//    undefined until written.
//  - A stalled response holds; the next search result waits in the engine
//    until the output register frees up.
//
module sorted_matrix_staircase_search_unit
    import smss_pkg::*;
#(
    parameter int MAX_ROWS    = MAX_ROWS_DEF,
    parameter int MAX_COLS    = MAX_COLS_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  req_valid,
    output logic                  req_stall,
    input  smss_in_t              req_item,

    output logic                  rsp_valid,
    input  logic                  rsp_stall,
    output smss_out_t             rsp_item,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [CFG_DATA_W-1:0] rows_cfg_reg;
    logic [CFG_DATA_W-1:0] cols_cfg_reg;

    logic                  rsp_valid_reg, rsp_valid_next;
    smss_out_t             rsp_item_reg, rsp_item_next;

    smss_ctrl_t            ctrl;
    smss_stat_t            stat;
    smss_out_t             eng_result;
    logic                  slot_free;

    // Config writes are always accepted
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_cfg_reg <= DIM_RESET;
            cols_cfg_reg <= DIM_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_ROWS_IDX: rows_cfg_reg <= cfg_data;
                CFG_COLS_IDX: cols_cfg_reg <= cfg_data;
                default:      ;  // unknown index: ignored
            endcase
        end
    end

    // Only an idle engine takes an item
    assign req_stall = !stat.idle;

    // Output register is free when empty or being drained this cycle
    assign slot_free     = !rsp_valid_reg || !rsp_stall;
    assign ctrl.start    = req_valid && !req_stall;
    assign ctrl.res_take = stat.res_valid && slot_free;

    smss_engine #(
        .MAX_ROWS    (MAX_ROWS),
        .MAX_COLS    (MAX_COLS),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .item     (req_item),
        .rows_cfg (rows_cfg_reg),
        .cols_cfg (cols_cfg_reg),
        .stat     (stat),
        .result   (eng_result)
    );

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_item_next  = rsp_item_reg;
        if (ctrl.res_take)
        begin
            rsp_valid_next = 1'b1;
            rsp_item_next  = eng_result;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_item_reg <= rsp_item_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_item  = rsp_item_reg;

endmodule
